// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the three-bin knapsack count block.
// Compiled out when ASSERT_OFF is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- hdl/kbc_pkg.sv -----
// Shared types, constants and helpers of the three-bin knapsack count block.
// No dependencies.
package kbc_pkg;

	localparam int WEIGHT_W   = 8;
	localparam int COUNT_W    = 8;
	localparam int CAP_W      = 4;
	localparam int CFG_ADDR_W = 2;

	typedef logic [WEIGHT_W-1:0]   weight_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [CAP_W-1:0]      cap_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t REG_CAP_FIRST  = 2'd0;
	localparam cfg_addr_t REG_CAP_SECOND = 2'd1;
	localparam cfg_addr_t REG_CAP_THIRD  = 2'd2;

	localparam count_t COUNT_MAX = '1;

	// saturating increment of a best count
	function automatic count_t sat_inc(input count_t v);
		return (v == COUNT_MAX) ? COUNT_MAX : count_t'(v + 1'b1);
	endfunction

endpackage

// ----- hdl/kbc_item_if.sv -----
// Input item channel: weight and last-item mark with valid/ready.
// Depends on kbc_pkg.
interface kbc_item_if;
	logic              valid;
	logic              ready;
	kbc_pkg::weight_t  item_weight;
	logic              item_last;

	modport source(output valid, item_weight, item_last, input ready);
	modport sink(input valid, item_weight, item_last, output ready);
endinterface

// ----- hdl/kbc_result_if.sv -----
// Result channel: best item count with valid/ready.
// Depends on kbc_pkg.
interface kbc_result_if;
	logic             valid;
	logic             ready;
	kbc_pkg::count_t  max_items;

	modport source(output valid, max_items, input ready);
	modport sink(input valid, max_items, output ready);
endinterface

// ----- hdl/kbc_cfg_if.sv -----
// Configuration write channel: register index and data with valid/ready.
// Depends on kbc_pkg.
interface kbc_cfg_if;
	logic                valid;
	logic                ready;
	kbc_pkg::cfg_addr_t  addr;
	kbc_pkg::cap_t       data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ----- hdl/three_bin_knapsack_count_unit.sv -----
// Three-bin knapsack count block, top level: config registers, walk sequencer.
// Depends on kbc_pkg, the kbc_*_if interfaces, kbc_table, kbc_max_unit.
//
// Usage: write the bin capacities on cfg (index 0, 1, 2) while the block is
// idle; cfg.ready is always high. Send item weights on item. Each item whose
// weight is at most CAP_MAX walks every capacity triple of the table in
// descending order, in states P0 and P1 for each entry, through one shared
// max unit; heavier items skip the walk. item.ready is high only while idle.
// On an item marked last the count at the full capacities is read back, in
// S_RDREQ and then S_RESULT, into the output register and shown on result;
// the table is then cleared, one entry a cycle. The same clearing pass runs
// after reset, with item.ready low. A stalled receiver holds the result in
// the output register; the next last item waits before its own read back
// until that transaction completes.
module three_bin_knapsack_count_unit #(
	parameter int CAP_MAX = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	kbc_item_if.sink          item,
	kbc_result_if.source      result,
	kbc_cfg_if.sink           cfg
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(CAP_MAX + 1);
	localparam int AW = 3 * CW;
	localparam int XW = (CW > kbc_pkg::CAP_W) ? CW : kbc_pkg::CAP_W;
	localparam logic [CW-1:0] CAP_TOP  = CW'(CAP_MAX);
	localparam logic [XW-1:0] CAP_TOPX = XW'(CAP_MAX);
	localparam logic [AW-1:0] CLR_LAST = '1;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_P0     = 3'd2;
	localparam logic [2:0] S_P1     = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_RDREQ  = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]      state_q;
	logic [AW-1:0]   clr_q;
	logic [CW-1:0]   a_q, b_q, c_q;
	logic [CW-1:0]   w_q;
	logic            wzero_q;
	logic            last_q;
	logic            pend_q;
	logic            ena_q, enb_q, enc_q;
	logic [AW-1:0]   wr_addr_q;
	kbc_pkg::count_t acc_q;
	kbc_pkg::count_t out_q;
	logic            out_valid_q;
	kbc_pkg::cap_t   cap_first_q, cap_second_q, cap_third_q;

	logic            tbl_we;
	logic [AW-1:0]   tbl_waddr;
	kbc_pkg::count_t tbl_wdata;
	logic [AW-1:0]   tbl_raddr0, tbl_raddr1;
	kbc_pkg::count_t tbl_rdata0, tbl_rdata1;

	kbc_pkg::count_t u_base, u_x, u_y, u_best;
	logic            u_inc, u_enx, u_eny;

	logic [CW-1:0]   am_w, bm_w, cm_w;
	logic [CW-1:0]   ra, rb, rc;
	logic [AW-1:0]   res_addr;
	logic            item_fits;
	logic            walk_end;

	// capacities clamped to the table side
	function automatic logic [CW-1:0] clamp_cap(input kbc_pkg::cap_t v);
		logic [XW-1:0] vx;
		vx = XW'(v);
		return (vx > CAP_TOPX) ? CAP_TOP : vx[CW-1:0];
	endfunction

	assign am_w      = a_q - w_q;
	assign bm_w      = b_q - w_q;
	assign cm_w      = c_q - w_q;
	assign ra        = clamp_cap(cap_first_q);
	assign rb        = clamp_cap(cap_second_q);
	assign rc        = clamp_cap(cap_third_q);
	assign res_addr  = {ra, rb, rc};
	assign item_fits = (item.item_weight <= kbc_pkg::WEIGHT_W'(CAP_MAX));
	assign walk_end  = (a_q == '0) && (b_q == '0) && (c_q == '0);

	assign item.ready     = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign result.valid   = out_valid_q;
	assign result.max_items = out_q;

	kbc_table #(
		.AW(AW),
		.DW(kbc_pkg::COUNT_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr0(tbl_raddr0),
		.raddr1(tbl_raddr1),
		.rdata0(tbl_rdata0),
		.rdata1(tbl_rdata1)
	);

	kbc_max_unit u_max (
		.base    (u_base),
		.inc_base(u_inc),
		.cand_x  (u_x),
		.en_x    (u_enx),
		.cand_y  (u_y),
		.en_y    (u_eny),
		.best    (u_best)
	);

	// P0 issues reads of the entry and its first-bin neighbor and retires the
	// previous entry with the second/third-bin neighbors; P1 folds the first
	// two values into acc_q and issues the other two neighbor reads.
	always_comb begin
		tbl_we     = 1'b0;
		tbl_waddr  = wr_addr_q;
		tbl_wdata  = u_best;
		tbl_raddr0 = {a_q, b_q, c_q};
		tbl_raddr1 = {am_w, b_q, c_q};
		u_base     = acc_q;
		u_inc      = 1'b0;
		u_x        = tbl_rdata0;
		u_enx      = enb_q;
		u_y        = tbl_rdata1;
		u_eny      = enc_q;
		unique case (state_q)
			S_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
			end
			S_P0: begin
				tbl_we = pend_q;
			end
			S_P1: begin
				tbl_raddr0 = {a_q, bm_w, c_q};
				tbl_raddr1 = {a_q, b_q, cm_w};
				u_base     = tbl_rdata0;
				u_inc      = wzero_q;
				u_x        = tbl_rdata1;
				u_enx      = ena_q;
				u_eny      = 1'b0;
			end
			S_DRAIN: begin
				tbl_we = 1'b1;
			end
			S_RDREQ, S_RESULT: begin
				tbl_raddr0 = res_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			cap_first_q  <= '0;
			cap_second_q <= '0;
			cap_third_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.addr)
					kbc_pkg::REG_CAP_FIRST:  cap_first_q  <= cfg.data;
					kbc_pkg::REG_CAP_SECOND: cap_second_q <= cfg.data;
					kbc_pkg::REG_CAP_THIRD:  cap_third_q  <= cfg.data;
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						pend_q <= 1'b0;
						if (item_fits) begin
							state_q <= S_P0;
						end else if (item.item_last) begin
							state_q <= S_RDREQ;
						end
					end
				end
				S_P0: begin
					state_q <= S_P1;
				end
				S_P1: begin
					pend_q  <= 1'b1;
					state_q <= walk_end ? S_DRAIN : S_P0;
				end
				S_DRAIN: begin
					state_q <= last_q ? S_RDREQ : S_IDLE;
				end
				S_RDREQ: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						clr_q       <= '0;
						state_q     <= S_CLEAR;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// walk datapath, no reset needed
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			w_q     <= item.item_weight[CW-1:0];
			wzero_q <= (item.item_weight == '0);
			last_q  <= item.item_last;
			a_q     <= CAP_TOP;
			b_q     <= CAP_TOP;
			c_q     <= CAP_TOP;
		end
		if (state_q == S_P0) begin
			ena_q <= (a_q >= w_q) && !wzero_q;
		end
		if (state_q == S_P1) begin
			enb_q     <= (b_q >= w_q) && !wzero_q;
			enc_q     <= (c_q >= w_q) && !wzero_q;
			acc_q     <= u_best;
			wr_addr_q <= {a_q, b_q, c_q};
			if (c_q == '0) begin
				c_q <= CAP_TOP;
				if (b_q == '0) begin
					b_q <= CAP_TOP;
					a_q <= a_q - 1'b1;
				end else begin
					b_q <= b_q - 1'b1;
				end
			end else begin
				c_q <= c_q - 1'b1;
			end
		end
		if ((state_q == S_RESULT) && !out_valid_q) begin
			out_q <= tbl_rdata0;
		end
	end

	`ASSERT_NEVER(a_idle_no_write, clk, arst_n, (state_q == S_IDLE) && tbl_we,
		"table written while idle")
	`ASSERT_PROP(a_walk_no_collide, clk, arst_n,
		(state_q == S_P0 && pend_q) |-> (tbl_raddr0 != tbl_waddr),
		"entry read while its own update retires")
	`ASSERT_PROP(a_result_from_read, clk, arst_n,
		$rose(out_valid_q) |-> $past(state_q == S_RESULT),
		"result loaded outside readback")
	`ASSERT_PROP(a_clear_runs, clk, arst_n,
		(state_q == S_CLEAR && clr_q != CLR_LAST) |=> (state_q == S_CLEAR),
		"clearing pass cut short")

endmodule

// ----- hdl/kbc_table.sv -----
// Best-count table: one write port, two registered read ports.
// No package dependencies.
module kbc_table #(
	parameter int AW = 12,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- hdl/kbc_max_unit.sv -----
// Shared compare unit: best of a base count and up to two incremented candidates.
// Depends on kbc_pkg.
module kbc_max_unit (
	input  kbc_pkg::count_t base,
	input  logic            inc_base,
	input  kbc_pkg::count_t cand_x,
	input  logic            en_x,
	input  kbc_pkg::count_t cand_y,
	input  logic            en_y,
	output kbc_pkg::count_t best
);

	kbc_pkg::count_t b0;
	kbc_pkg::count_t cx;
	kbc_pkg::count_t cy;
	kbc_pkg::count_t m;

	always_comb begin
		b0 = inc_base ? kbc_pkg::sat_inc(base) : base;
		cx = kbc_pkg::sat_inc(cand_x);
		cy = kbc_pkg::sat_inc(cand_y);
		m  = b0;
		if (en_x && (cx > m)) begin
			m = cx;
		end
		if (en_y && (cy > m)) begin
			m = cy;
		end
		best = m;
	end

endmodule

// ----- tb/tb_three_bin_knapsack_count_unit.sv -----
// Testbench for three_bin_knapsack_count_unit: random and directed item sets are
// checked against an in-bench best-count table. Depends on kbc_pkg and the
// kbc_item_if, kbc_result_if and kbc_cfg_if interfaces.
module tb_three_bin_knapsack_count_unit;

	localparam int CAP_MAX        = 15;
	localparam int SIDE           = CAP_MAX + 1;
	localparam int TABLE_DEPTH    = SIDE * SIDE * SIDE;
	// one full walk, the read back and a clearing pass, with margin
	localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + TABLE_DEPTH + 64;
	localparam int WATCHDOG_LIMIT = 4 * (2 * TABLE_DEPTH + TABLE_DEPTH + 4) + 1000;

	typedef struct packed {
		kbc_pkg::weight_t weight;
		logic             last;
	} item_t;

	logic clk;
	logic arst_n;

	kbc_item_if   item_ch();
	kbc_result_if result_ch();
	kbc_cfg_if    cfg_ch();

	three_bin_knapsack_count_unit #(.CAP_MAX(CAP_MAX)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	kbc_pkg::count_t best_counts [TABLE_DEPTH];
	kbc_pkg::cap_t   bin_caps [3];
	item_t           pending_items [$];
	kbc_pkg::count_t predicted_counts [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int n_items;
	int n_counts;
	int n_settings;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int tbl_idx(input int a, input int b, input int c);
		return (a * SIDE + b) * SIDE + c;
	endfunction

	function automatic kbc_pkg::count_t bump(input kbc_pkg::count_t v);
		return (v == 8'hff) ? v : kbc_pkg::count_t'(v + 8'd1);
	endfunction

	function automatic int clamp_cap(input kbc_pkg::cap_t v);
		return (int'(v) > CAP_MAX) ? CAP_MAX : int'(v);
	endfunction

	// in-place descending walk, so each item is taken at most once
	function automatic void absorb_weight(input kbc_pkg::weight_t w);
		kbc_pkg::count_t best;
		kbc_pkg::count_t cand;
		int wi;
		wi = int'(w);
		if (wi > CAP_MAX)
			return;
		for (int a = CAP_MAX; a >= 0; a--)
			for (int b = CAP_MAX; b >= 0; b--)
				for (int c = CAP_MAX; c >= 0; c--) begin
					best = best_counts[tbl_idx(a, b, c)];
					if (wi == 0) begin
						best = bump(best);
					end else begin
						if (a >= wi) begin
							cand = bump(best_counts[tbl_idx(a - wi, b, c)]);
							if (cand > best) best = cand;
						end
						if (b >= wi) begin
							cand = bump(best_counts[tbl_idx(a, b - wi, c)]);
							if (cand > best) best = cand;
						end
						if (c >= wi) begin
							cand = bump(best_counts[tbl_idx(a, b, c - wi)]);
							if (cand > best) best = cand;
						end
					end
					best_counts[tbl_idx(a, b, c)] = best;
				end
	endfunction

	function automatic void clear_counts();
		foreach (best_counts[i])
			best_counts[i] = '0;
	endfunction

	function automatic kbc_pkg::weight_t pick_weight();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 50) return kbc_pkg::weight_t'($urandom_range(1, 4));
		if (r < 82) return kbc_pkg::weight_t'($urandom_range(5, CAP_MAX));
		return kbc_pkg::weight_t'($urandom_range(CAP_MAX + 1, 255));
	endfunction

	// driver: one transaction per handshake, prediction on acceptance
	always @(posedge clk) begin
		item_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				n_items++;
				absorb_weight(item_ch.item_weight);
				if (item_ch.item_last) begin
					predicted_counts = {predicted_counts,
						best_counts[tbl_idx(clamp_cap(bin_caps[0]),
						clamp_cap(bin_caps[1]), clamp_cap(bin_caps[2]))]};
					clear_counts();
				end
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					item_ch.valid       <= 1'b1;
					item_ch.item_weight <= nxt.weight;
					item_ch.item_last   <= nxt.last;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		kbc_pkg::count_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (predicted_counts.size() == 0) begin
					$display("%0t: unexpected max_items, expected none, got %0d",
						$time, result_ch.max_items);
					fail_count++;
				end else begin
					want = predicted_counts.pop_front();
					n_counts++;
					if (result_ch.max_items !== want) begin
						$display("%0t: max_items mismatch, expected %0d, got %0d",
							$time, want, result_ch.max_items);
						fail_count++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input kbc_pkg::cfg_addr_t idx, input kbc_pkg::cap_t v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			kbc_pkg::REG_CAP_FIRST: begin
				bin_caps[0] = v;
			end
			kbc_pkg::REG_CAP_SECOND: begin
				bin_caps[1] = v;
			end
			kbc_pkg::REG_CAP_THIRD: begin
				bin_caps[2] = v;
			end
			default: begin
			end
		endcase
	endtask

	task automatic write_caps(input kbc_pkg::cap_t c0, input kbc_pkg::cap_t c1,
			input kbc_pkg::cap_t c2);
		write_reg(kbc_pkg::REG_CAP_FIRST, c0);
		write_reg(kbc_pkg::REG_CAP_SECOND, c1);
		write_reg(kbc_pkg::REG_CAP_THIRD, c2);
		n_settings++;
	endtask

	task automatic write_random_caps();
		write_caps(kbc_pkg::cap_t'($urandom_range(0, 15)),
			kbc_pkg::cap_t'($urandom_range(0, 15)),
			kbc_pkg::cap_t'($urandom_range(0, 15)));
	endtask

	task automatic queue_item(input int w, input bit last);
		item_t it;
		it.weight = kbc_pkg::weight_t'(w);
		it.last   = last;
		pending_items = {pending_items, it};
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_ch.valid || predicted_counts.size() > 0)
			@(posedge clk);
	endtask

	// drain, then let a clearing pass or a leftover walk finish
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random sets, each closed by a last item; oversized non-last items do not count
	task automatic queue_random_sets(input int target);
		int live;
		int len;
		item_t it;
		live = 0;
		while (live < target) begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				it.weight = pick_weight();
				it.last   = (k == len - 1);
				if (int'(it.weight) <= CAP_MAX || it.last)
					live++;
				pending_items = {pending_items, it};
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.item_weight = '0;
		item_ch.item_last   = 1'b0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.addr         = kbc_pkg::REG_CAP_FIRST;
		cfg_ch.data         = '0;
		bin_caps            = '{default: '0};
		clear_counts();
		fail_count   = 0;
		n_items      = 0;
		n_counts     = 0;
		n_settings   = 0;
		quiet_cycles = 0;
		send_idle_pct = 17;
		recv_idle_pct = 64;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty bins: only zero weights fit
		write_caps('0, '0, '0);
		queue_item(0, 1);
		queue_item(5, 1);
		queue_item(255, 1);
		queue_item(0, 0);
		queue_item(0, 0);
		queue_item(16, 1);
		settle();

		write_caps(4'hf, 4'hf, 4'hf);
		repeat (4) queue_item(15, 0);
		queue_item(15, 1);
		repeat (5) queue_item(8, 0);
		queue_item(1, 1);
		queue_item(1, 0);
		queue_item(2, 0);
		queue_item(4, 0);
		queue_item(8, 1);
		queue_item(16, 1);
		queue_item(128, 0);
		queue_item(0, 1);
		// hold the sender until every count is back
		wait_drained();
		queue_random_sets(20);
		settle();
		write_random_caps();
		queue_random_sets(20);
		settle();

		send_idle_pct = 64;
		recv_idle_pct = 17;
		// zero weights: every entry gains one per item
		write_caps(4'hf, 4'h0, 4'h7);
		for (int k = 0; k < 8; k++)
			queue_item(0, k == 7);
		settle();
		write_random_caps();
		queue_random_sets(20);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_caps(4'hf, 4'hf, 4'hf);
		queue_random_sets(15);
		settle();
		write_random_caps();
		queue_random_sets(20);
		settle();

		$display("Covered %0d items and %0d checked counts over %0d bin settings,",
			n_items, n_counts, n_settings);
		$display("including empty and full bins, oversized and zero weights, stalls on each side.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
